@@ rtl/skf_pkg.sv @@
package skf_pkg;

  // default widths of the fixed-point format
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load;      // capture sample, form difference and denominator
    logic div_step;  // one restoring division step of the gain
    logic mul_load;  // set up both shift-add multipliers
    logic mul_step;  // one shift-add step in both multipliers
    logic commit;    // write new estimate and variance
  } cmd_t;

endpackage

@@ rtl/skf_ctrl.sv @@
module skf_ctrl #(
  parameter int unsigned FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output skf_pkg::cmd_t cmd_o
);
  import skf_pkg::*;

  localparam int unsigned CW = $clog2(FRAC_BITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  cmd_t          cmd;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd         = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          cnt_d    = CW'(FRAC_BITS - 1);
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_d        = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd.mul_load = 1'b1;
        cnt_d        = CW'(FRAC_BITS);
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_d        = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.commit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.div_step, cmd.mul_load, cmd.mul_step, cmd.commit}))
    else $error("more than one datapath command at once");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> state_q == S_DONE)
    else $error("result overwritten while output stalled");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DIV && !in_ready_o))
    else $error("accepted beat did not start the gain division");

endmodule

@@ rtl/skf_dp.sv @@
module skf_dp #(
  parameter int unsigned DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  skf_pkg::cmd_t                     cmd_i,
  input  logic                              cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_WIDTH-1:0]             cfg_data_i,
  input  logic signed [DATA_WIDTH-1:0]      sample_i,
  output logic signed [DATA_WIDTH-1:0]      estimate_o
);
  import skf_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned AW = DW + FB + 2;
  localparam logic [DW-1:0] ONE_FIX = {{(DW-1){1'b0}}, 1'b1} << FB;
  localparam logic [FB:0]   ONE_GAIN = {1'b1, {FB{1'b0}}};

  logic [DW-1:0] q_noise_q, r_noise_q;
  logic [DW-1:0] est_q, var_q;

  // per-sample working registers
  logic          neg_q, rzero_q, pzero_q;
  logic [DW:0]   mag_q, den_q, rem_q;
  logic [FB-1:0] quo_q;
  logic [AW-1:0] ma_q, pa_q, acc_m_q, acc_p_q;
  logic [FB:0]   mb_q, pb_q;

  // difference and its magnitude
  logic [DW:0] diff;
  assign diff = {sample_i[DW-1], sample_i} - {est_q[DW-1], est_q};

  // restoring division step
  logic [DW+1:0] rem2, den2, rem_sub;
  logic          ge;
  assign rem2    = {rem_q, 1'b0};
  assign den2    = {1'b0, den_q};
  assign ge      = (rem2 >= den2);
  assign rem_sub = rem2 - den2;

  // gain with the zero-noise cases folded in
  logic [FB-1:0] gain;
  always_comb begin
    if (rzero_q) begin
      gain = pzero_q ? '0 : '1;
    end else begin
      gain = quo_q;
    end
  end

  // update terms
  logic [DW:0] m_term, est_sum, var_sum;
  assign m_term  = acc_m_q[FB +: DW+1];
  assign est_sum = neg_q ? ({est_q[DW-1], est_q} - m_term) : ({est_q[DW-1], est_q} + m_term);
  assign var_sum = {1'b0, acc_p_q[FB +: DW]} + {1'b0, q_noise_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= ONE_FIX;
      r_noise_q <= ONE_FIX;
      est_q     <= '0;
      var_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_PROCESS_NOISE: q_noise_q <= cfg_data_i;
          REG_MEASURE_NOISE: r_noise_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        est_q <= est_sum[DW-1:0];
        var_q <= var_sum[DW] ? '1 : var_sum[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q   <= diff[DW];
      mag_q   <= diff[DW] ? (~diff + 1'b1) : diff;
      den_q   <= {1'b0, var_q} + {1'b0, r_noise_q};
      rem_q   <= {1'b0, var_q};
      quo_q   <= '0;
      rzero_q <= (r_noise_q == '0);
      pzero_q <= (var_q == '0);
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[DW:0] : rem2[DW:0];
      quo_q <= {quo_q[FB-2:0], ge};
    end
    if (cmd_i.mul_load) begin
      ma_q    <= AW'(mag_q);
      mb_q    <= {1'b0, gain};
      pa_q    <= AW'(var_q);
      pb_q    <= ONE_GAIN - {1'b0, gain};
      acc_m_q <= '0;
      acc_p_q <= '0;
    end
    if (cmd_i.mul_step) begin
      acc_m_q <= acc_m_q + (mb_q[0] ? ma_q : '0);
      acc_p_q <= acc_p_q + (pb_q[0] ? pa_q : '0);
      ma_q    <= {ma_q[AW-2:0], 1'b0};
      pa_q    <= {pa_q[AW-2:0], 1'b0};
      mb_q    <= {1'b0, mb_q[FB:1]};
      pb_q    <= {1'b0, pb_q[FB:1]};
    end
  end

  assign estimate_o = est_q;

  a_mul_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (mb_q == '0 && pb_q == '0))
    else $error("commit before both multipliers finished");

endmodule

@@ rtl/scalar_kalman_filter.sv @@
// scalar kalman filter, constant-state model, fixed point
//
// input channel: in_valid_i / in_ready_o with sample_i (signed, FRAC_BITS
// fraction bits). each accepted beat yields exactly one beat on the output
// channel out_valid_o / out_ready_i carrying estimate_o.
// configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 = process noise Q, 1 = measurement noise R); other indexes are ignored.
// write only while no sample is in flight.
// sequence from accept to output valid: FRAC_BITS restoring-division steps
// form the gain, then a setup step, then FRAC_BITS+1 steps of two shift-add
// multipliers running side by side, then a commit step.
// a single sequencer and the shared division and multiply units hold one
// sample at a time; the next sample is taken only once the last is committed.
// reset: estimate and variance go to zero, Q and R to 1.0.
// back-pressure: estimate_o sits in its own register, so a new sample is
// taken while the last estimate waits; if that estimate is still not taken
// when the next one is ready, the block holds in its commit cycle.
module scalar_kalman_filter #(
  parameter int unsigned DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_WIDTH-1:0]         cfg_data_i,
  // sample beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]  sample_i,
  // estimate beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [DATA_WIDTH-1:0]  estimate_o
);
  import skf_pkg::*;

  cmd_t cmd;

  // sequencer: division, multiply and commit phases plus output valid
  skf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath: noise registers, filter state, divider and multipliers
  skf_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .estimate_o  (estimate_o)
  );

endmodule
